@@ src/bb5_pkg.sv @@
// Shared constants and types for the 5x5 box blur unit.
package bb5_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int BORDER      = 2;
    localparam int STORE_DEPTH = MAX_WIDTH + 2 * BORDER;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 13;
    localparam int SUM_W   = 11;
    localparam int TOTAL_W = 13;
    localparam int LINE_W  = 4 * PIX_W;

    localparam int BLUR_SCALE = 5243;
    localparam int BLUR_SHIFT = 17;
    localparam int PROD_W     = 26;
    localparam int QUOT_W     = PROD_W - BLUR_SHIFT;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;
        logic line_end;
        logic frame_end;
    } t_flags;

endpackage

@@ src/bb5_ram.sv @@
// Simple dual-port RAM with registered read.
module bb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2052
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/box_blur_5x5_u8_unit.sv @@
// 5x5 box blur of a padded 8-bit raster stream, one pixel per clock while the output is not stalled.
// An accepted input word passes the stage 1, stage 2 and output registers on its way to its output word.
// The line store does one read and one write per pixel.
// Reset clears the counters, the column sums and the pipeline valids, and sets
// the size registers to 640 x 480; the line store is not cleared and fills over
// the first four padded rows of a frame.
module box_blur_5x5_u8_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bb5_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bb5_pkg::PIX_W-1:0]   o_blurred,
    output logic                        o_line_end,
    output logic                        o_frame_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [0:0]                  i_cfg_index,
    input  logic [bb5_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW = bb5_pkg::ADDR_W;

    // configuration
    logic [bb5_pkg::CFG_W-1:0] r_width;
    logic [bb5_pkg::CFG_W-1:0] r_height;

    // position counters
    logic [bb5_pkg::COL_W-1:0] r_col;
    logic [bb5_pkg::ROW_W-1:0] r_row;

    // stage 1
    logic                      r_v1;
    logic [bb5_pkg::PIX_W-1:0] r_pix1;
    logic [AW-1:0]             r_addr1;
    bb5_pkg::t_flags           r_flags1;

    // stage 2
    logic                        r_v2;
    logic [bb5_pkg::TOTAL_W-1:0] r_total2;
    bb5_pkg::t_flags             r_flags2;

    // output
    logic                      r_out_valid;
    logic [bb5_pkg::PIX_W-1:0] r_blurred;
    logic                      r_line_end;
    logic                      r_frame_end;

    logic [bb5_pkg::SUM_W-1:0] r_csum [4];

    logic ld_out, ld2, ld1, accept;
    logic [bb5_pkg::CFG_W-1:0] w_eff, h_eff;
    logic [bb5_pkg::COL_W-1:0] last_col_pos;
    logic [bb5_pkg::ROW_W-1:0] last_row_pos;
    logic                      is_last_col, is_last_row;
    bb5_pkg::t_flags           flags0;
    logic [AW-1:0]             addr0;
    logic [bb5_pkg::LINE_W-1:0] old_word, new_word;
    logic [bb5_pkg::SUM_W-1:0]  vsum;
    logic [bb5_pkg::TOTAL_W-1:0] total;
    logic                        store_we;
    logic [bb5_pkg::PROD_W-1:0]  prod;
    logic [bb5_pkg::QUOT_W-1:0]  quot;
    logic [bb5_pkg::PIX_W-1:0]   blur_sat;

    assign ld_out = !r_out_valid || i_ready;
    assign ld2    = !r_v2 || ld_out;
    assign ld1    = !r_v1 || ld2;
    assign accept = i_valid && ld1;

    assign o_ready     = ld1;
    assign o_cfg_ready = 1'b1;

    // stage 0: position and flags
    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = bb5_pkg::CFG_W'(1);
        end else if (r_width > bb5_pkg::CFG_W'(bb5_pkg::MAX_WIDTH)) begin
            w_eff = bb5_pkg::CFG_W'(bb5_pkg::MAX_WIDTH);
        end
        h_eff = (r_height == '0) ? bb5_pkg::CFG_W'(1) : r_height;
        last_col_pos = bb5_pkg::COL_W'(w_eff) + bb5_pkg::COL_W'(2 * bb5_pkg::BORDER - 1);
        last_row_pos = bb5_pkg::ROW_W'(h_eff) + bb5_pkg::ROW_W'(2 * bb5_pkg::BORDER - 1);
        is_last_col  = r_col >= last_col_pos;
        is_last_row  = r_row >= last_row_pos;
        flags0.emit      = (r_row >= bb5_pkg::ROW_W'(2 * bb5_pkg::BORDER)) &&
                           (r_col >= bb5_pkg::COL_W'(2 * bb5_pkg::BORDER));
        flags0.line_end  = is_last_col;
        flags0.frame_end = is_last_col && is_last_row;
        if (r_col < bb5_pkg::COL_W'(bb5_pkg::STORE_DEPTH)) begin
            addr0 = AW'(r_col);
        end else begin
            addr0 = AW'(bb5_pkg::STORE_DEPTH - 1);
        end
    end

    // stage 1: vertical sum and window total
    always_comb begin
        vsum = bb5_pkg::SUM_W'(old_word[7:0]) + bb5_pkg::SUM_W'(old_word[15:8]) +
               bb5_pkg::SUM_W'(old_word[23:16]) + bb5_pkg::SUM_W'(old_word[31:24]) +
               bb5_pkg::SUM_W'(r_pix1);
        new_word = {old_word[bb5_pkg::LINE_W-bb5_pkg::PIX_W-1:0], r_pix1};
        total = bb5_pkg::TOTAL_W'(r_csum[0]) + bb5_pkg::TOTAL_W'(r_csum[1]) +
                bb5_pkg::TOTAL_W'(r_csum[2]) + bb5_pkg::TOTAL_W'(r_csum[3]) +
                bb5_pkg::TOTAL_W'(vsum);
    end

    assign store_we = r_v1 && ld2;

    bb5_ram #(
        .WIDTH (bb5_pkg::LINE_W),
        .DEPTH (bb5_pkg::STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_addr1),
        .i_wdata (new_word),
        .i_re    (ld1),
        .i_raddr (addr0),
        .o_rdata (old_word)
    );

    // stage 2: scale, round, saturate
    always_comb begin
        prod = bb5_pkg::PROD_W'(r_total2) * bb5_pkg::PROD_W'(bb5_pkg::BLUR_SCALE) +
               bb5_pkg::PROD_W'(1 << (bb5_pkg::BLUR_SHIFT - 1));
        quot = prod[bb5_pkg::PROD_W-1:bb5_pkg::BLUR_SHIFT];
        blur_sat = (quot > bb5_pkg::QUOT_W'(255)) ? 8'hFF : quot[bb5_pkg::PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= bb5_pkg::WIDTH_RESET;
            r_height    <= bb5_pkg::HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_csum[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bb5_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    bb5_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (is_last_col) begin
                    r_col <= '0;
                    r_row <= is_last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (ld1) begin
                r_v1 <= accept;
            end
            if (ld2) begin
                r_v2 <= r_v1 && r_flags1.emit;
            end
            if (ld_out) begin
                r_out_valid <= r_v2;
            end
            if (store_we) begin
                r_csum[0] <= r_csum[1];
                r_csum[1] <= r_csum[2];
                r_csum[2] <= r_csum[3];
                r_csum[3] <= vsum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_pix1   <= i_pixel_in;
            r_addr1  <= addr0;
            r_flags1 <= flags0;
        end
        if (ld2) begin
            r_total2 <= total;
            r_flags2 <= r_flags1;
        end
        if (ld_out) begin
            r_blurred   <= blur_sat;
            r_line_end  <= r_flags2.line_end;
            r_frame_end <= r_flags2.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_blurred   = r_blurred;
    assign o_line_end  = r_line_end;
    assign o_frame_end = r_frame_end;

endmodule

@@ verif/tb_box_blur_5x5_u8_unit.sv @@
// Self-checking testbench for the 5x5 box blur unit: directed and random padded frames against a bit-true predictor.
module tb_box_blur_5x5_u8_unit;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PIXELS = 850;

    typedef enum int {PIX_RANDOM, PIX_MAX, PIX_ZERO, PIX_LOW, PIX_HIGH} t_pix_mode;

    typedef struct packed {
        logic [bb5_pkg::PIX_W-1:0] blurred;
        logic                      line_end;
        logic                      frame_end;
    } t_blur_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [bb5_pkg::PIX_W-1:0]   i_pixel_in = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [bb5_pkg::PIX_W-1:0]   o_blurred;
    logic                        o_line_end;
    logic                        o_frame_end;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [0:0]                  i_cfg_index = '0;
    logic [bb5_pkg::CFG_W-1:0]   i_cfg_data = '0;

    box_blur_5x5_u8_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_blurred   (o_blurred),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic [bb5_pkg::CFG_W-1:0]  pred_width = bb5_pkg::WIDTH_RESET;
    logic [bb5_pkg::CFG_W-1:0]  pred_height = bb5_pkg::HEIGHT_RESET;
    logic [bb5_pkg::COL_W-1:0]  col_pos = '0;
    logic [bb5_pkg::ROW_W-1:0]  row_pos = '0;
    logic [bb5_pkg::LINE_W-1:0] line_mem [bb5_pkg::STORE_DEPTH];
    logic [bb5_pkg::SUM_W-1:0]  col_sums [5];

    t_blur_word                blur_expect_q[$];
    logic [bb5_pkg::PIX_W-1:0] pix_pending[$];

    int px_queued = 0;
    int px_taken = 0;
    int blur_owed = 0;
    int cfg_count = 0;
    int err_count = 0;
    int idle_cycles = 0;

    // Sender and receiver pacing
    logic        sender_gappy = 1'b0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  pat_pos = '0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        in_fire = 1'b0;

    function automatic int padded_w();
        int w;
        w = pred_width;
        if (w == 0) w = 1;
        if (w > bb5_pkg::MAX_WIDTH) w = bb5_pkg::MAX_WIDTH;
        return w + 2 * bb5_pkg::BORDER;
    endfunction

    function automatic int padded_h();
        int h;
        h = pred_height;
        if (h == 0) h = 1;
        return h + 2 * bb5_pkg::BORDER;
    endfunction

    // Pixels still needed to bring the counters back to the top left corner
    function automatic int frame_left();
        int pw, ph, n;
        pw = padded_w();
        ph = padded_h();
        n = (col_pos >= pw - 1) ? 1 : pw - int'(col_pos);
        if (row_pos < ph - 1) n += (ph - 1 - int'(row_pos)) * pw;
        return n;
    endfunction

    task automatic blur_predict(input logic [bb5_pkg::PIX_W-1:0] pix);
        int pw, ph, idx, vsum, total, q;
        logic [bb5_pkg::LINE_W-1:0] old;
        logic last_col, last_row;
        t_blur_word w;
        pw = padded_w();
        ph = padded_h();
        idx = (col_pos < bb5_pkg::STORE_DEPTH) ? int'(col_pos) : bb5_pkg::STORE_DEPTH - 1;
        old = line_mem[idx];
        vsum = int'(old[7:0]) + int'(old[15:8]) + int'(old[23:16]) + int'(old[31:24])
             + int'(pix);
        last_col = (col_pos >= pw - 1);
        last_row = (row_pos >= ph - 1);
        line_mem[idx] = {old[23:0], pix};
        for (int k = 0; k < 4; k++) col_sums[k] = col_sums[k + 1];
        col_sums[4] = bb5_pkg::SUM_W'(vsum);
        if (row_pos >= 2 * bb5_pkg::BORDER && col_pos >= 2 * bb5_pkg::BORDER) begin
            total = 0;
            for (int k = 0; k < 5; k++) total += int'(col_sums[k]);
            q = (total * bb5_pkg::BLUR_SCALE + (1 << (bb5_pkg::BLUR_SHIFT - 1)))
                >> bb5_pkg::BLUR_SHIFT;
            if (q > 255) q = 255;
            w.blurred = bb5_pkg::PIX_W'(q);
            w.line_end = last_col;
            w.frame_end = last_col && last_row;
            blur_expect_q.push_back(w);
        end
        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        err_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Monitor: checks output words, feeds the predictor with accepted input words
    always @(posedge i_clk) begin : monitor
        t_blur_word want;
        if (i_rst_n) begin
            in_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (blur_expect_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected word, expected none, got %0h %0b %0b",
                             $time, o_blurred, o_line_end, o_frame_end);
                end else begin
                    want = blur_expect_q.pop_front();
                    if (o_blurred !== want.blurred)
                        flag_mismatch("blurred", want.blurred, o_blurred);
                    if (o_line_end !== want.line_end)
                        flag_mismatch("line_end", 8'(want.line_end), 8'(o_line_end));
                    if (o_frame_end !== want.frame_end)
                        flag_mismatch("frame_end", 8'(want.frame_end), 8'(o_frame_end));
                end
            end
            if (i_valid && o_ready) begin
                blur_predict(i_pixel_in);
                px_taken <= px_taken + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bb5_pkg::CFG_IMAGE_WIDTH) pred_width = i_cfg_data;
                else pred_height = i_cfg_data;
                cfg_count <= cfg_count + 1;
            end
            blur_owed <= blur_expect_q.size();
        end
    end

    // Driver: bursty pixel sender and patterned receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= stall_pat[pat_pos];
            pat_pos <= pat_pos + 1'b1;
            if (!i_valid || in_fire) begin
                if (pix_pending.size() > 0 && gap_left == 0) begin
                    i_valid <= 1'b1;
                    i_pixel_in <= pix_pending.pop_front();
                    if (sender_gappy) begin
                        if (burst_left <= 1) begin
                            burst_left <= $urandom_range(1, 40);
                            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end else begin
                            burst_left <= burst_left - 1;
                        end
                    end
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("box_blur_5x5_u8_unit test failed");
                $finish;
            end
        end
    end

    function automatic logic [bb5_pkg::PIX_W-1:0] gen_pix(input t_pix_mode mode);
        case (mode)
            PIX_MAX:  return 8'hFF;
            PIX_ZERO: return 8'h00;
            PIX_LOW:  return bb5_pkg::PIX_W'($urandom_range(0, 3));
            PIX_HIGH: return bb5_pkg::PIX_W'($urandom_range(250, 255));
            default:  return bb5_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixels(input int n, input t_pix_mode mode);
        for (int k = 0; k < n; k++) begin
            pix_pending.push_back(gen_pix(mode));
            px_queued++;
        end
    endtask

    task automatic settle();
        wait (px_taken == px_queued && blur_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input int val);
        int target;
        target = cfg_count + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= bb5_pkg::CFG_W'(val);
        wait (cfg_count == target);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_size(input int w, input int h);
        if ($urandom_range(0, 1)) begin
            cfg_write(bb5_pkg::CFG_IMAGE_WIDTH, w);
            cfg_write(bb5_pkg::CFG_IMAGE_HEIGHT, h);
        end else begin
            cfg_write(bb5_pkg::CFG_IMAGE_HEIGHT, h);
            cfg_write(bb5_pkg::CFG_IMAGE_WIDTH, w);
        end
    endtask

    task automatic pick_timing();
        sender_gappy = ($urandom_range(0, 2) != 0);
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    endtask

    task automatic run_frame(input int w, input int h, input t_pix_mode mode);
        pick_timing();
        write_size(w, h);
        push_pixels(frame_left(), mode);
        settle();
    endtask

    initial begin : stimulus
        int w, h, left, cut, rand_pixels;
        t_pix_mode mode;
        for (int k = 0; k < bb5_pkg::STORE_DEPTH; k++) line_mem[k] = '0;
        for (int k = 0; k < 5; k++) col_sums[k] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Smallest frame, saturated pixels: single word with both flags set
        run_frame(1, 1, PIX_MAX);
        // Zero sizes act as one
        run_frame(0, 0, PIX_ZERO);

        rand_pixels = 0;
        while (rand_pixels < RANDOM_PIXELS) begin
            pick_timing();
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            write_size(w, h);
            mode = ($urandom_range(0, 2) != 0) ? PIX_RANDOM : t_pix_mode'($urandom_range(1, 4));
            left = frame_left();
            if ($urandom_range(0, 3) == 0 && left > 1) begin
                // Stop mid-frame, resize, then finish the frame under the new size
                cut = $urandom_range(1, left - 1);
                push_pixels(cut, mode);
                rand_pixels += cut;
                settle();
                if ($urandom_range(0, 1))
                    cfg_write(bb5_pkg::CFG_IMAGE_WIDTH,
                              $urandom_range(0, padded_w() - 2 * bb5_pkg::BORDER));
                else
                    cfg_write(bb5_pkg::CFG_IMAGE_HEIGHT, $urandom_range(0, 8));
                left = frame_left();
            end
            push_pixels(left, mode);
            rand_pixels += left;
            settle();
        end

        if (err_count == 0) begin
            $display("box_blur_5x5_u8_unit test passed");
        end else begin
            $display("box_blur_5x5_u8_unit test failed");
        end
        $finish;
    end

endmodule

@@ box_blur_5x5_u8_unit.f @@
src/bb5_pkg.sv
src/bb5_ram.sv
src/box_blur_5x5_u8_unit.sv
verif/tb_box_blur_5x5_u8_unit.sv
